/* hdl/fedf_pkg.sv */
// Shared types and constants for the evicting duplicate filter.
`default_nettype none
package fedf_pkg;

	// Full message hash width and the width of the count fields
	localparam int KEY_W   = 256;
	localparam int FIELD_W = 7;

	// Reset value of the cache limit register
	localparam logic [FIELD_W-1:0] CACHE_LIMIT_RESET = 7'd64;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_PRUNE = 1'b1
	} opcode_t;

endpackage
`default_nettype wire

/* hdl/fedf_match_array.sv */
// Hash store with one comparator per slot and the combined hit flag.
`default_nettype none
module fedf_match_array #(
	parameter int STORE_DEPTH = 64
) (
	input  wire                               clk,
	input  wire fedf_pkg::key_t               key,
	input  wire  [STORE_DEPTH-1:0]            held,
	input  wire                               wr_en,
	input  wire  [$clog2(STORE_DEPTH)-1:0]    wr_slot,
	output logic                              hit
);
	import fedf_pkg::*;

	key_t                   store_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] match_vec;

	// Write the new hash into its ring slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_slot] <= key;
		end
	end

	// Compare every held slot against the key
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cmp
		assign match_vec[i] = held[i] && (store_q[i] == key);
	end

	assign hit = |match_vec;

endmodule
`default_nettype wire

/* hdl/fedf_ring_ctrl.sv */
// Ring pointer and count update for insert, duplicate and prune transactions.
`default_nettype none
module fedf_ring_ctrl #(
	parameter int STORE_DEPTH = 64
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	input  wire fedf_pkg::opcode_t                opcode,
	input  wire                                   hit,
	input  wire  [fedf_pkg::FIELD_W-1:0]          prune_target,
	input  wire  [fedf_pkg::FIELD_W-1:0]          cache_limit,
	output logic [STORE_DEPTH-1:0]                held,
	output logic                                  wr_en,
	output logic [$clog2(STORE_DEPTH)-1:0]        wr_slot,
	output logic [$clog2(STORE_DEPTH+1)-1:0]      count_next
);
	import fedf_pkg::*;

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int MW = (CW > FIELD_W) ? CW : FIELD_W;
	localparam logic [CW:0]   DEPTH_W = (CW+1)'(STORE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

	logic [IW-1:0] oldest_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] oldest_next;

	logic          full;
	logic [CW:0]   wsum;
	logic [IW-1:0] oldest_ins1;
	logic [CW-1:0] count_ins2;
	logic [CW-1:0] limit_eff;
	logic [CW-1:0] evict_ins;
	logic [CW:0]   osum_ins;
	logic [CW-1:0] evict_prn;
	logic [CW:0]   osum_prn;
	logic          prune_hit;

	// Mark slots inside the held window of the ring
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_held
		logic [IW:0] slot_ofs;
		always_comb begin
			if ((IW+1)'(i) >= (IW+1)'(oldest_q)) begin
				slot_ofs = (IW+1)'(i) - (IW+1)'(oldest_q);
			end else begin
				slot_ofs = (IW+1)'(i) + (IW+1)'(STORE_DEPTH) - (IW+1)'(oldest_q);
			end
			held[i] = (CW+1)'(slot_ofs) < (CW+1)'(count_q);
		end
	end

	// Clamp the limit at the store depth
	always_comb begin
		if (MW'(cache_limit) > MW'(STORE_DEPTH)) begin
			limit_eff = DEPTH_C;
		end else begin
			limit_eff = CW'(cache_limit);
		end
	end

	// Insert path: append at the slot after the newest, then evict down to the limit
	always_comb begin
		full = (count_q == DEPTH_C);
		wsum = (CW+1)'(oldest_q) + (CW+1)'(count_q);
		if (wsum >= DEPTH_W) begin
			wsum = wsum - DEPTH_W;
		end
		if (!full) begin
			oldest_ins1 = oldest_q;
			count_ins2  = count_q + 1'b1;
		end else begin
			oldest_ins1 = (oldest_q == IW'(STORE_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
			count_ins2  = DEPTH_C;
		end
		evict_ins = (count_ins2 > limit_eff) ? count_ins2 - limit_eff : '0;
		osum_ins  = (CW+1)'(oldest_ins1) + (CW+1)'(evict_ins);
		if (osum_ins >= DEPTH_W) begin
			osum_ins = osum_ins - DEPTH_W;
		end
	end

	// Prune path: drop oldest entries down to the target
	always_comb begin
		prune_hit = MW'(count_q) > MW'(prune_target);
		evict_prn = prune_hit ? count_q - CW'(prune_target) : '0;
		osum_prn  = (CW+1)'(oldest_q) + (CW+1)'(evict_prn);
		if (osum_prn >= DEPTH_W) begin
			osum_prn = osum_prn - DEPTH_W;
		end
	end

	// Select the next ring state
	always_comb begin
		wr_en       = 1'b0;
		wr_slot     = IW'(wsum);
		oldest_next = oldest_q;
		count_next  = count_q;
		if (item_valid) begin
			case (opcode)
				OP_CHECK: begin
					if (!hit) begin
						wr_en       = 1'b1;
						oldest_next = IW'(osum_ins);
						count_next  = (count_ins2 > limit_eff) ? limit_eff : count_ins2;
					end
				end
				OP_PRUNE: begin
					if (prune_hit) begin
						oldest_next = IW'(osum_prn);
						count_next  = CW'(prune_target);
					end
				end
				default: begin
					oldest_next = oldest_q;
				end
			endcase
		end
	end

	// Hold ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			oldest_q <= oldest_next;
			count_q  <= count_next;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("held count above store depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(oldest_q) < DEPTH_W)
		else $error("oldest slot out of range");

	a_dup_stable: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && opcode == OP_CHECK && hit |=> $stable(count_q) && $stable(oldest_q))
		else $error("duplicate transaction changed the ring");

	a_insert_limit: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && opcode == OP_CHECK && !hit |=> count_q == $past(count_next) &&
			count_q <= $past(limit_eff) &&
			(CW+1)'(count_q) <= (CW+1)'($past(count_q)) + 1'b1)
		else $error("insert left count above limit");

	a_prune_target: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && opcode == OP_PRUNE |=> MW'(count_q) <= MW'($past(prune_target)) ||
			count_q == $past(count_q))
		else $error("prune left count above target");
`endif

endmodule
`default_nettype wire

/* hdl/fifo_evicting_dedup_filter_unit.sv */
// Top level of the FIFO-evicting duplicate filter for 256-bit message hashes.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. busy stays low, so one transaction can be issued each cycle.
//   opcode check compares key_word_3..key_word_0 with all held hashes and
//   inserts it on a miss; opcode prune shrinks a larger set to prune_target.
//   Result channel: done is high for exactly one cycle per transaction, with
//   is_new and occupancy valid in that cycle. The accepting edge loads the
//   input register; the next edge loads done and the result register
//   through the compare array and ring update.
//   Throughput is one transaction per cycle, set by the combinational parallel
//   compare of all STORE_DEPTH slots feeding the ring pointer update.
//   The receiver has no stall; every result must be taken when done is high.
//   Config channel: cfg_ready is always high; cfg_data loads the cache limit.
//   Write it only while no transaction is in flight.
//   Reset: arst_n clears the ring to empty and the cache limit to 64. The
//   hash store itself is not cleared; only slots in the held window are read.
`default_nettype none
module fifo_evicting_dedup_filter_unit #(
	parameter int STORE_DEPTH = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire fedf_pkg::opcode_t          opcode,
	input  wire  [63:0]                     key_word_0,
	input  wire  [63:0]                     key_word_1,
	input  wire  [63:0]                     key_word_2,
	input  wire  [63:0]                     key_word_3,
	input  wire  [fedf_pkg::FIELD_W-1:0]    prune_target,
	output logic                            done,
	output logic                            is_new,
	output logic [fedf_pkg::FIELD_W-1:0]    occupancy,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [fedf_pkg::FIELD_W-1:0]    cfg_data
);
	import fedf_pkg::*;

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic                   valid_s1;
	opcode_t                opcode_s1;
	key_t                   key_s1;
	logic [FIELD_W-1:0]     target_s1;
	logic [FIELD_W-1:0]     cache_limit_q;

	logic [STORE_DEPTH-1:0] held;
	logic                   hit;
	logic                   wr_en;
	logic [IW-1:0]          wr_slot;
	logic [CW-1:0]          count_next;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Load the cache limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_limit_q <= CACHE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cache_limit_q <= cfg_data;
		end
	end

	// Capture the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1 <= opcode;
			key_s1    <= {key_word_3, key_word_2, key_word_1, key_word_0};
			target_s1 <= prune_target;
		end
	end

	fedf_match_array #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_match (
		.clk     (clk),
		.key     (key_s1),
		.held    (held),
		.wr_en   (wr_en),
		.wr_slot (wr_slot),
		.hit     (hit)
	);

	fedf_ring_ctrl #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.opcode       (opcode_s1),
		.hit          (hit),
		.prune_target (target_s1),
		.cache_limit  (cache_limit_q),
		.held         (held),
		.wr_en        (wr_en),
		.wr_slot      (wr_slot),
		.count_next   (count_next)
	);

	// Register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			is_new    <= wr_en;
			occupancy <= FIELD_W'(count_next);
		end
	end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the evicting duplicate filter against a hash-set predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fedf_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int STORE_DEPTH = 64;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 100;
	localparam int RECENT_MAX  = 128;

	// Expected outcome of one command
	typedef struct packed {
		logic               is_new;
		logic [FIELD_W-1:0] occupancy;
	} verdict_t;

	// Tracks the held hash set in insertion order and the verdicts still due
	class dedup_scoreboard;
		key_t        held_keys[$];
		verdict_t    due_verdicts[$];
		int unsigned cache_limit;
		int unsigned failures;

		function new();
			cache_limit = CACHE_LIMIT_RESET;
			failures    = 0;
		endfunction

		function void set_limit(logic [FIELD_W-1:0] value);
			cache_limit = value;
		endfunction

		function int pending();
			return due_verdicts.size();
		endfunction

		// Apply one accepted command to the held set and queue its verdict
		function void note_command(opcode_t op, key_t key, logic [FIELD_W-1:0] target);
			bit          hit;
			int unsigned eff_limit;
			verdict_t    v;
			hit       = 1'b0;
			eff_limit = (cache_limit > STORE_DEPTH) ? STORE_DEPTH : cache_limit;
			v.is_new  = 1'b0;
			if (op == OP_CHECK) begin
				foreach (held_keys[i])
					if (held_keys[i] == key)
						hit = 1'b1;
				if (!hit) begin
					// free the oldest slot of a full ring, then append and trim
					if (held_keys.size() >= STORE_DEPTH)
						held_keys.delete(0);
					held_keys = {held_keys, key};
					while (held_keys.size() > eff_limit)
						held_keys.delete(0);
					v.is_new = 1'b1;
				end
			end else begin
				while (held_keys.size() > target)
					held_keys.delete(0);
			end
			v.occupancy = FIELD_W'(held_keys.size());
			due_verdicts = {due_verdicts, v};
		endfunction

		// Compare one result with the oldest verdict due
		function void check_verdict(logic is_new, logic [FIELD_W-1:0] occupancy);
			verdict_t v;
			if (due_verdicts.size() == 0) begin
				$error("result strobe with no command outstanding");
				failures++;
				return;
			end
			v = due_verdicts[0];
			due_verdicts.delete(0);
			if (is_new !== v.is_new) begin
				$error("is_new: expected %0b, got %0b", v.is_new, is_new);
				failures++;
			end
			if (occupancy !== v.occupancy) begin
				$error("occupancy: expected %0d, got %0d", v.occupancy, occupancy);
				failures++;
			end
		endfunction
	endclass

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               busy;
	opcode_t            opcode       = OP_CHECK;
	logic [63:0]        key_word_0   = '0;
	logic [63:0]        key_word_1   = '0;
	logic [63:0]        key_word_2   = '0;
	logic [63:0]        key_word_3   = '0;
	logic [FIELD_W-1:0] prune_target = '0;
	logic               done;
	logic               is_new;
	logic [FIELD_W-1:0] occupancy;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [FIELD_W-1:0] cfg_data     = '0;

	dedup_scoreboard sb = new();
	key_t            recent_keys[$];

	fifo_evicting_dedup_filter_unit #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.key_word_0  (key_word_0),
		.key_word_1  (key_word_1),
		.key_word_2  (key_word_2),
		.key_word_3  (key_word_3),
		.prune_target(prune_target),
		.done        (done),
		.is_new      (is_new),
		.occupancy   (occupancy),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Check every result strobe
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_verdict(is_new, occupancy);
	end

	// Stop a hung run
	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic key_t fresh_key();
		key_t k;
		for (int i = 0; i < KEY_W / 32; i++)
			k[32*i +: 32] = $urandom;
		return k;
	endfunction

	// Drive one command and hold it until the block takes it
	task automatic issue(opcode_t op, key_t key, logic [FIELD_W-1:0] target);
		@(negedge clk);
		start        = 1'b1;
		opcode       = op;
		{key_word_3, key_word_2, key_word_1, key_word_0} = key;
		prune_target = target;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(op, key, target);
	endtask

	task automatic check_key(key_t key);
		issue(OP_CHECK, key, FIELD_W'($urandom_range(127)));
	endtask

	task automatic prune_to(int unsigned target);
		issue(OP_PRUNE, fresh_key(), FIELD_W'(target));
	endtask

	task automatic idle_for(int unsigned cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(int unsigned value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = FIELD_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_limit(FIELD_W'(value));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One random command: mostly checks mixing repeats, near misses and fresh hashes
	task automatic random_command(int unsigned prune_pct);
		int unsigned roll;
		int unsigned count;
		int unsigned target;
		key_t        key;
		roll  = $urandom_range(99);
		count = sb.held_keys.size();
		if (roll < prune_pct) begin
			case ($urandom_range(3))
				0: target = $urandom_range(127);
				1: target = count;
				2: target = $urandom_range(count);
				default: target = $urandom_range(1) ? 127 : 0;
			endcase
			prune_to(target);
		end else begin
			roll = $urandom_range(99);
			if (roll < 35 && recent_keys.size() != 0) begin
				key = recent_keys[$urandom_range(recent_keys.size() - 1)];
			end else if (roll < 45 && count != 0) begin
				key = sb.held_keys[$urandom_range(count - 1)];
				key[$urandom_range(KEY_W - 1)] ^= 1'b1;
			end else if (roll < 55 && count != 0) begin
				key = sb.held_keys[$urandom_range(count - 1)];
			end else begin
				key = fresh_key();
				recent_keys = {recent_keys, key};
				if (recent_keys.size() > RECENT_MAX)
					recent_keys.delete(0);
			end
			check_key(key);
		end
	endtask

	initial begin
		int unsigned phase_limit[PHASES] = '{127, 65, 0, 2, 64, 1, 63, 100, 0, 0, 64};
		int unsigned phase_prune[PHASES] = '{3, 5, 10, 10, 3, 10, 5, 3, 12, 15, 8};
		int unsigned phase_idle[PHASES]  = '{20, 0, 30, 15, 25, 20, 0, 30, 15, 20, 0};
		key_t        key_a;
		key_t        key_b;

		// Hold reset, then release between edges
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme hashes, a flipped top bit in each word, prune edges
		check_key('0);
		check_key('1);
		check_key('0);
		for (int w = 0; w < 4; w++)
			check_key(key_t'(1) << (64 * w + 63));
		check_key('1);
		prune_to(127);
		prune_to(sb.held_keys.size());
		prune_to(2);
		check_key('0);
		prune_to(0);
		check_key('0);
		drain();

		// Limit zero: every insert is evicted at once
		write_limit(0);
		key_a = fresh_key();
		key_b = fresh_key();
		check_key(key_a);
		check_key(key_a);
		prune_to(0);
		drain();

		// Limit one: the second insert pushes out the first
		write_limit(1);
		check_key(key_a);
		check_key(key_b);
		check_key(key_a);
		check_key(key_a);
		drain();

		// Random phases under changing limits; the last has no gaps
		phase_limit[8] = $urandom_range(3, 62);
		phase_limit[9] = $urandom_range(127);
		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limit[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < phase_idle[p])
					idle_for($urandom_range(1, 9));
				random_command(phase_prune[p]);
			end
			drain();
		end

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
